// ===== hdl/multi_keyword_match_counter_macros.svh =====
// assertion macros for the keyword match counter
`ifndef MULTI_KEYWORD_MATCH_COUNTER_MACROS_SVH
`define MULTI_KEYWORD_MATCH_COUNTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MKMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MKMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mkmc_pkg.sv =====
// shared types and constants for the keyword match counter
package mkmc_pkg;

    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_KEYWORD = 2'd1;
    localparam logic [1:0] KIND_TEXT    = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] symbol;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [15:0] match_count;
        logic        table_full;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLEAR,
        OP_ROWCLR,
        OP_KW_ENTER,
        OP_KW_RD,
        OP_KW_CHK,
        OP_KW_LINK,
        OP_KWC_RD,
        OP_KWC_WR,
        OP_KW_END,
        OP_B_INIT,
        OP_B_POP,
        OP_B_DONE,
        OP_B_POPW,
        OP_B_CHRD,
        OP_B_CHW,
        OP_B_FW,
        OP_B_MRD,
        OP_B_MCHK,
        OP_B_NEXTI,
        OP_T_INIT,
        OP_T_RD,
        OP_T_CHK,
        OP_T_FW,
        OP_C_INIT,
        OP_C_RD,
        OP_C_ADD,
        OP_FIN
    } t_op;

    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        logic       sym_ok;
        logic       drop;
        logic       links;
        logic       child_zero;
        logic       full;
        logic       row_last;
        logic       i_last;
        logic       q_more;
        logic       p_zero;
        logic       t_zero;
        logic       mark;
    } t_stat;

endpackage

// ===== hdl/mkmc_dp.sv =====
// datapath: node tables, link queue, cursor and running total
module mkmc_dp #(
    parameter int MAX_NODES = 16384,
    parameter int ALPHABET  = 26
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mkmc_pkg::t_in   i_in,
    input  mkmc_pkg::t_op   i_op,
    output mkmc_pkg::t_stat o_stat,
    output mkmc_pkg::t_out  o_res,
    output logic            o_valid
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = NW + 1;
    localparam int IW  = $clog2(ALPHABET);
    localparam int CAW = $clog2(MAX_NODES * ALPHABET);

    logic [NW-1:0] child_mem [0:MAX_NODES*ALPHABET-1];
    logic [NW-1:0] fail_mem  [0:MAX_NODES-1];
    logic [15:0]   kwc_mem   [0:MAX_NODES-1];
    logic          mark_mem  [0:MAX_NODES-1];
    logic [NW-1:0] queue_mem [0:MAX_NODES-1];

    mkmc_pkg::t_in  r_in, n_in;
    mkmc_pkg::t_out r_res, n_res;
    logic           r_vld, n_vld;
    logic [NW-1:0]  r_cur, n_cur;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_tail, n_tail;
    logic           r_links, n_links;
    logic [15:0]    r_total, n_total;
    logic           r_ovf, n_ovf;
    logic           r_drop, n_drop;
    logic [NW-1:0]  r_p, n_p;
    logic [IW-1:0]  r_i, n_i;
    logic [NW-1:0]  r_c, n_c;
    logic [NW-1:0]  r_t, n_t;
    logic [IW-1:0]  r_j, n_j;
    logic [NW-1:0]  r_rnode, n_rnode;

    logic [NW-1:0]  r_ch_q;
    logic [NW-1:0]  r_fl_q;
    logic [15:0]    r_kc_q;
    logic           r_mk_q;
    logic [NW-1:0]  r_qu_q;

    logic           ch_we;
    logic [CAW-1:0] ch_waddr, ch_raddr;
    logic [NW-1:0]  ch_wdata;
    logic           fl_we;
    logic [NW-1:0]  fl_waddr, fl_raddr, fl_wdata;
    logic           kc_we;
    logic [NW-1:0]  kc_addr;
    logic [15:0]    kc_wdata;
    logic           mk_we;
    logic [NW-1:0]  mk_addr;
    logic           mk_wdata;
    logic           qu_we;
    logic [NW-1:0]  qu_waddr, qu_raddr, qu_wdata;

    logic           sym_ok;
    logic           full;
    logic           tail_ok;
    logic [16:0]    sum;

    function automatic logic [CAW-1:0] f_caddr(input logic [NW-1:0] node,
                                               input logic [CAW-1:0] sym);
        return CAW'(node) * CAW'(ALPHABET) + sym;
    endfunction

    assign sym_ok  = 9'(r_in.symbol) < 9'(ALPHABET);
    assign full    = r_cnt == CW'(MAX_NODES);
    assign tail_ok = r_tail < CW'(MAX_NODES);
    assign sum     = {1'b0, r_total} + {1'b0, r_kc_q};

    always_comb begin
        o_stat.kind       = r_in.kind;
        o_stat.last       = r_in.last;
        o_stat.sym_ok     = sym_ok;
        o_stat.drop       = r_drop;
        o_stat.links      = r_links;
        o_stat.child_zero = r_ch_q == '0;
        o_stat.full       = full;
        o_stat.row_last   = r_j == IW'(ALPHABET - 1);
        o_stat.i_last     = r_i == IW'(ALPHABET - 1);
        o_stat.q_more     = r_head != r_tail;
        o_stat.p_zero     = r_p == '0;
        o_stat.t_zero     = r_t == '0;
        o_stat.mark       = r_mk_q;
    end

    always_comb begin
        n_in    = r_in;
        n_res   = r_res;
        n_vld   = 1'b0;
        n_cur   = r_cur;
        n_cnt   = r_cnt;
        n_head  = r_head;
        n_tail  = r_tail;
        n_links = r_links;
        n_total = r_total;
        n_ovf   = r_ovf;
        n_drop  = r_drop;
        n_p     = r_p;
        n_i     = r_i;
        n_c     = r_c;
        n_t     = r_t;
        n_j     = r_j;
        n_rnode = r_rnode;

        ch_we    = 1'b0;
        ch_waddr = f_caddr(r_cur, CAW'(r_in.symbol));
        ch_wdata = r_c;
        ch_raddr = f_caddr(r_p, CAW'(r_i));
        fl_we    = 1'b0;
        fl_waddr = r_c;
        fl_wdata = '0;
        fl_raddr = r_p;
        kc_we    = 1'b0;
        kc_addr  = r_cur;
        kc_wdata = '0;
        mk_we    = 1'b0;
        mk_addr  = r_t;
        mk_wdata = 1'b0;
        qu_we    = 1'b0;
        qu_waddr = r_tail[NW-1:0];
        qu_wdata = r_c;
        qu_raddr = r_head[NW-1:0];

        case (i_op)
            mkmc_pkg::OP_ACCEPT: begin
                n_in = i_in;
            end
            mkmc_pkg::OP_CLEAR: begin
                n_cnt   = CW'(1);
                n_head  = '0;
                n_tail  = '0;
                n_cur   = '0;
                n_links = 1'b0;
                n_total = '0;
                n_ovf   = 1'b0;
                n_drop  = 1'b0;
                n_rnode = '0;
                n_j     = '0;
            end
            mkmc_pkg::OP_ROWCLR: begin
                ch_we    = 1'b1;
                ch_waddr = f_caddr(r_rnode, CAW'(r_j));
                ch_wdata = '0;
                kc_we    = 1'b1;
                kc_addr  = r_rnode;
                mk_we    = 1'b1;
                mk_addr  = r_rnode;
                n_j      = o_stat.row_last ? '0 : r_j + IW'(1);
            end
            mkmc_pkg::OP_KW_ENTER: begin
                if (r_links) begin
                    n_links = 1'b0;
                    n_cur   = '0;
                    n_total = '0;
                end
            end
            mkmc_pkg::OP_KW_RD: begin
                ch_raddr = f_caddr(r_cur, CAW'(r_in.symbol));
            end
            mkmc_pkg::OP_KW_CHK: begin
                if (r_ch_q != '0) begin
                    n_cur = r_ch_q;
                end else if (!full) begin
                    n_c     = r_cnt[NW-1:0];
                    n_rnode = r_cnt[NW-1:0];
                    n_cnt   = r_cnt + CW'(1);
                    n_j     = '0;
                end else begin
                    n_ovf  = 1'b1;
                    n_drop = 1'b1;
                end
            end
            mkmc_pkg::OP_KW_LINK: begin
                ch_we = 1'b1;
                n_cur = r_c;
            end
            mkmc_pkg::OP_KWC_RD: begin
                kc_addr = r_cur;
            end
            mkmc_pkg::OP_KWC_WR: begin
                kc_we    = 1'b1;
                kc_wdata = (r_kc_q == mkmc_pkg::COUNT_MAX) ? r_kc_q : r_kc_q + 16'd1;
                n_drop   = 1'b0;
                n_cur    = '0;
            end
            mkmc_pkg::OP_KW_END: begin
                n_drop = 1'b0;
                n_cur  = '0;
            end
            mkmc_pkg::OP_B_INIT: begin
                n_head   = '0;
                n_tail   = CW'(1);
                fl_we    = 1'b1;
                fl_waddr = '0;
                qu_we    = 1'b1;
                qu_waddr = '0;
                qu_wdata = '0;
                n_drop   = 1'b0;
            end
            mkmc_pkg::OP_B_POP: begin
                n_head = r_head + CW'(1);
            end
            mkmc_pkg::OP_B_DONE: begin
                n_links = 1'b1;
                n_cur   = '0;
            end
            mkmc_pkg::OP_B_POPW: begin
                n_p = r_qu_q;
                n_i = '0;
            end
            mkmc_pkg::OP_B_CHRD: begin
                ch_raddr = f_caddr(r_p, CAW'(r_i));
            end
            mkmc_pkg::OP_B_CHW: begin
                n_c = r_ch_q;
                if (r_ch_q != '0 && r_p == '0) begin
                    fl_we    = 1'b1;
                    fl_waddr = r_ch_q;
                    qu_we    = tail_ok;
                    qu_wdata = r_ch_q;
                    if (tail_ok) begin
                        n_tail = r_tail + CW'(1);
                    end
                end
            end
            mkmc_pkg::OP_B_FW: begin
                n_t = r_fl_q;
            end
            mkmc_pkg::OP_B_MRD: begin
                ch_raddr = f_caddr(r_t, CAW'(r_i));
            end
            mkmc_pkg::OP_B_MCHK: begin
                if (r_ch_q != '0 || r_t == '0) begin
                    fl_we    = 1'b1;
                    fl_wdata = r_ch_q;
                    qu_we    = tail_ok;
                    if (tail_ok) begin
                        n_tail = r_tail + CW'(1);
                    end
                end else begin
                    fl_raddr = r_t;
                end
            end
            mkmc_pkg::OP_B_NEXTI: begin
                if (!o_stat.i_last) begin
                    n_i = r_i + IW'(1);
                end
            end
            mkmc_pkg::OP_T_INIT: begin
                n_p = sym_ok ? r_cur : '0;
            end
            mkmc_pkg::OP_T_RD: begin
                ch_raddr = f_caddr(r_p, CAW'(r_in.symbol));
            end
            mkmc_pkg::OP_T_CHK: begin
                if (r_ch_q != '0) begin
                    n_p = r_ch_q;
                end
            end
            mkmc_pkg::OP_T_FW: begin
                n_p = r_fl_q;
            end
            mkmc_pkg::OP_C_INIT: begin
                n_cur = r_p;
                n_t   = r_p;
            end
            mkmc_pkg::OP_C_RD: begin
                kc_addr  = r_t;
                fl_raddr = r_t;
            end
            mkmc_pkg::OP_C_ADD: begin
                n_total  = sum[16] ? mkmc_pkg::COUNT_MAX : sum[15:0];
                mk_we    = 1'b1;
                mk_wdata = 1'b1;
                n_t      = r_fl_q;
            end
            mkmc_pkg::OP_FIN: begin
                if (r_in.last) begin
                    n_res.match_count = r_total;
                    n_res.table_full  = r_ovf;
                    n_vld             = 1'b1;
                    n_total           = '0;
                    n_cur             = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_cur   <= '0;
            r_cnt   <= CW'(1);
            r_head  <= '0;
            r_tail  <= '0;
            r_links <= 1'b0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_drop  <= 1'b0;
            r_j     <= '0;
            r_rnode <= '0;
        end else begin
            r_vld   <= n_vld;
            r_cur   <= n_cur;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_links <= n_links;
            r_total <= n_total;
            r_ovf   <= n_ovf;
            r_drop  <= n_drop;
            r_j     <= n_j;
            r_rnode <= n_rnode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_res <= n_res;
        r_p   <= n_p;
        r_i   <= n_i;
        r_c   <= n_c;
        r_t   <= n_t;
    end

    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            child_mem[ch_waddr] <= ch_wdata;
        end
        r_ch_q <= child_mem[ch_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            fail_mem[fl_waddr] <= fl_wdata;
        end
        r_fl_q <= fail_mem[fl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (kc_we) begin
            kwc_mem[kc_addr] <= kc_wdata;
        end
        r_kc_q <= kwc_mem[kc_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            mark_mem[mk_addr] <= mk_wdata;
        end
        r_mk_q <= mark_mem[mk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (qu_we) begin
            queue_mem[qu_waddr] <= qu_wdata;
        end
        r_qu_q <= queue_mem[qu_raddr];
    end

    assign o_res   = r_res;
    assign o_valid = r_vld;

endmodule

// ===== hdl/mkmc_ctrl.sv =====
// controller: sequences insertion, link build and text scan
module mkmc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  mkmc_pkg::t_stat i_stat,
    output mkmc_pkg::t_op   o_op,
    output logic            busy
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_ROWCLR,
        S_KW_DEC, S_KW_CHK, S_KW_LINK, S_KW_LAST, S_KW_INC,
        S_B_INIT, S_B_POP, S_B_POPW, S_B_CH, S_B_CHW, S_B_FW, S_B_MRD, S_B_MCHK,
        S_B_NEXTI,
        S_T_INIT, S_T_RD, S_T_CHK, S_T_FW,
        S_C_INIT, S_C_TEST, S_C_CHK, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_ret_kw, n_ret_kw;

    always_comb begin
        n_state  = r_state;
        n_ret_kw = r_ret_kw;
        o_op     = mkmc_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = mkmc_pkg::OP_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.kind)
                    mkmc_pkg::KIND_CLEAR: begin
                        o_op     = mkmc_pkg::OP_CLEAR;
                        n_ret_kw = 1'b0;
                        n_state  = S_ROWCLR;
                    end
                    mkmc_pkg::KIND_KEYWORD: begin
                        o_op    = mkmc_pkg::OP_KW_ENTER;
                        n_state = S_KW_DEC;
                    end
                    mkmc_pkg::KIND_TEXT: begin
                        n_state = i_stat.links ? S_T_INIT : S_B_INIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ROWCLR: begin
                o_op = mkmc_pkg::OP_ROWCLR;
                if (i_stat.row_last) begin
                    n_state = r_ret_kw ? S_KW_LINK : S_IDLE;
                end
            end
            S_KW_DEC: begin
                if (i_stat.sym_ok && !i_stat.drop) begin
                    o_op    = mkmc_pkg::OP_KW_RD;
                    n_state = S_KW_CHK;
                end else begin
                    n_state = S_KW_LAST;
                end
            end
            S_KW_CHK: begin
                o_op = mkmc_pkg::OP_KW_CHK;
                if (!i_stat.child_zero || i_stat.full) begin
                    n_state = S_KW_LAST;
                end else begin
                    n_ret_kw = 1'b1;
                    n_state  = S_ROWCLR;
                end
            end
            S_KW_LINK: begin
                o_op    = mkmc_pkg::OP_KW_LINK;
                n_state = S_KW_LAST;
            end
            S_KW_LAST: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (!i_stat.drop) begin
                    o_op    = mkmc_pkg::OP_KWC_RD;
                    n_state = S_KW_INC;
                end else begin
                    o_op    = mkmc_pkg::OP_KW_END;
                    n_state = S_IDLE;
                end
            end
            S_KW_INC: begin
                o_op    = mkmc_pkg::OP_KWC_WR;
                n_state = S_IDLE;
            end
            S_B_INIT: begin
                o_op    = mkmc_pkg::OP_B_INIT;
                n_state = S_B_POP;
            end
            S_B_POP: begin
                if (i_stat.q_more) begin
                    o_op    = mkmc_pkg::OP_B_POP;
                    n_state = S_B_POPW;
                end else begin
                    o_op    = mkmc_pkg::OP_B_DONE;
                    n_state = S_T_INIT;
                end
            end
            S_B_POPW: begin
                o_op    = mkmc_pkg::OP_B_POPW;
                n_state = S_B_CH;
            end
            S_B_CH: begin
                o_op    = mkmc_pkg::OP_B_CHRD;
                n_state = S_B_CHW;
            end
            S_B_CHW: begin
                o_op    = mkmc_pkg::OP_B_CHW;
                n_state = (i_stat.child_zero || i_stat.p_zero) ? S_B_NEXTI : S_B_FW;
            end
            S_B_FW: begin
                o_op    = mkmc_pkg::OP_B_FW;
                n_state = S_B_MRD;
            end
            S_B_MRD: begin
                o_op    = mkmc_pkg::OP_B_MRD;
                n_state = S_B_MCHK;
            end
            S_B_MCHK: begin
                o_op    = mkmc_pkg::OP_B_MCHK;
                n_state = (!i_stat.child_zero || i_stat.t_zero) ? S_B_NEXTI : S_B_FW;
            end
            S_B_NEXTI: begin
                o_op    = mkmc_pkg::OP_B_NEXTI;
                n_state = i_stat.i_last ? S_B_POP : S_B_CH;
            end
            S_T_INIT: begin
                o_op    = mkmc_pkg::OP_T_INIT;
                n_state = i_stat.sym_ok ? S_T_RD : S_C_INIT;
            end
            S_T_RD: begin
                o_op    = mkmc_pkg::OP_T_RD;
                n_state = S_T_CHK;
            end
            S_T_CHK: begin
                o_op    = mkmc_pkg::OP_T_CHK;
                n_state = (!i_stat.child_zero || i_stat.p_zero) ? S_C_INIT : S_T_FW;
            end
            S_T_FW: begin
                o_op    = mkmc_pkg::OP_T_FW;
                n_state = S_T_RD;
            end
            S_C_INIT: begin
                o_op    = mkmc_pkg::OP_C_INIT;
                n_state = S_C_TEST;
            end
            S_C_TEST: begin
                if (i_stat.t_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_op    = mkmc_pkg::OP_C_RD;
                    n_state = S_C_CHK;
                end
            end
            S_C_CHK: begin
                if (i_stat.mark) begin
                    n_state = S_FIN;
                end else begin
                    o_op    = mkmc_pkg::OP_C_ADD;
                    n_state = S_C_TEST;
                end
            end
            S_FIN: begin
                o_op    = mkmc_pkg::OP_FIN;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // reset lands in the root row clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ROWCLR;
            r_ret_kw <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret_kw <= n_ret_kw;
        end
    end

    assign busy = r_state != S_IDLE;

endmodule

// ===== hdl/multi_keyword_match_counter.sv =====
// top level of the Aho-Corasick keyword match counter
// One item is taken while busy is low and start is high; busy then stays high
// until the item is finished. After reset, and after a clear item, the root's
// child row is swept, one entry a cycle. When a keyword symbol allocates a
// node, its new child row is swept the same way through the child table's
// single write port. A text symbol follows failure links and then adds up the
// newly counted nodes, each step being one registered read of a table memory.
// The first text symbol after keywords, or after a clear, also runs the
// breadth-first link build. The result of a text's last symbol shows on o_res
// for one cycle with o_valid high, as busy drops; the receiver cannot stall it.
`include "multi_keyword_match_counter_macros.svh"

module multi_keyword_match_counter #(
    parameter int MAX_NODES = 16384,
    parameter int ALPHABET  = 26
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mkmc_pkg::t_in  i_in,
    output mkmc_pkg::t_out o_res,
    output logic           o_valid
);

    mkmc_pkg::t_op   op;
    mkmc_pkg::t_stat stat;

    mkmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_op    (op),
        .busy    (busy)
    );

    mkmc_dp #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_op    (op),
        .o_stat  (stat),
        .o_res   (o_res),
        .o_valid (o_valid)
    );

    `MKMC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted transfer did not raise busy")
    `MKMC_ASSERT_IMPL(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while still busy")
    `MKMC_ASSERT_NEXT(a_result_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result held longer than one cycle")

endmodule
